### rtl/core/sha1_message_hasher_assert.svh
// ----------------------------------------------------------------------------
// SHA-1 message hasher assertion macros
// Shared macros that wrap concurrent assertions on the hasher's ports.
// ----------------------------------------------------------------------------
`ifndef SHA1_MESSAGE_HASHER_ASSERT_SVH
`define SHA1_MESSAGE_HASHER_ASSERT_SVH

// Checked only while reset is low.
`define SHA1MH_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define SHA1MH_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

### rtl/core/sha1mh_pkg.sv
// ----------------------------------------------------------------------------
// SHA-1 message hasher package
// Types, constants and round functions shared by the hasher modules.
// ----------------------------------------------------------------------------
package sha1mh_pkg;

   typedef logic [31:0]         word_type;
   typedef word_type [4:0]      chain_type;
   typedef word_type [15:0]     block_type;
   typedef logic [6:0]          round_type;
   typedef logic [60:0]         total_type;
   typedef logic [2:0]          word_idx_type;

   localparam chain_type INIT_CHAIN = '{
      32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
   };

   localparam word_type K_ROUND0 = 32'h5A827999;
   localparam word_type K_ROUND1 = 32'h6ED9EBA1;
   localparam word_type K_ROUND2 = 32'h8F1BBCDC;
   localparam word_type K_ROUND3 = 32'hCA62C1D6;

   localparam round_type PHASE1_START = 7'd20;
   localparam round_type PHASE2_START = 7'd40;
   localparam round_type PHASE3_START = 7'd60;
   localparam round_type LAST_ROUND   = 7'd79;

   localparam logic [7:0]   PAD_MARKER    = 8'h80;
   localparam logic [5:0]   LENGTH_OFFSET = 6'd56;
   localparam logic [5:0]   LAST_BYTE_POS = 6'd63;
   localparam word_idx_type LAST_WORD_IDX = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HASH_DATA,
      ST_PAD_FIRST,
      ST_HASH_PAD,
      ST_PAD_LEN,
      ST_EMIT
   } hasher_state_type;

   typedef struct packed {
      logic start;
      logic reinit;
   } engine_ctl_type;

   typedef struct packed {
      logic done;
   } engine_status_type;

   function automatic word_type round_const(input round_type rnd);
      word_type k;
      if (rnd < PHASE1_START) begin
         k = K_ROUND0;
      end else if (rnd < PHASE2_START) begin
         k = K_ROUND1;
      end else if (rnd < PHASE3_START) begin
         k = K_ROUND2;
      end else begin
         k = K_ROUND3;
      end
      return k;
   endfunction

   function automatic word_type round_mix(input round_type rnd, input word_type b,
                                          input word_type c, input word_type d);
      word_type f;
      if (rnd < PHASE1_START) begin
         f = (b & c) | (~b & d);
      end else if (rnd >= PHASE2_START && rnd < PHASE3_START) begin
         f = (b & c) | (b & d) | (c & d);
      end else begin
         f = b ^ c ^ d;
      end
      return f;
   endfunction

endpackage

### rtl/core/sha1mh_round_engine.sv
// ----------------------------------------------------------------------------
// SHA-1 round engine
// Runs the 80 compression rounds one per cycle and folds into the chain.
// ----------------------------------------------------------------------------
module sha1mh_round_engine (
   input  logic                          clock,
   input  logic                          reset,
   input  sha1mh_pkg::engine_ctl_type    ctl,
   input  sha1mh_pkg::block_type         block,
   output sha1mh_pkg::engine_status_type status,
   output sha1mh_pkg::chain_type         chain
);
   import sha1mh_pkg::*;

   chain_type chain_ff, chain_in;
   chain_type work_ff, work_in;
   block_type window_ff, window_in;
   round_type rnd_ff, rnd_in;
   logic      running_ff, running_in;
   logic      fold_ff, fold_in;

   word_type  temp_sum;
   word_type  sched_new;

   // Work word 0 is a, word 4 is e. The window holds the next 16 schedule words.
   always_comb begin
      temp_sum = {work_ff[0][26:0], work_ff[0][31:27]}
               + round_mix(rnd_ff, work_ff[1], work_ff[2], work_ff[3])
               + work_ff[4] + round_const(rnd_ff) + window_ff[0];
      sched_new = window_ff[13] ^ window_ff[8] ^ window_ff[2] ^ window_ff[0];
      sched_new = {sched_new[30:0], sched_new[31]};
   end

   always_comb begin
      chain_in   = chain_ff;
      work_in    = work_ff;
      window_in  = window_ff;
      rnd_in     = rnd_ff;
      running_in = running_ff;
      fold_in    = 1'b0;
      if (ctl.start) begin
         work_in    = chain_ff;
         window_in  = block;
         rnd_in     = '0;
         running_in = 1'b1;
      end else if (running_ff) begin
         work_in[0] = temp_sum;
         work_in[1] = work_ff[0];
         work_in[2] = {work_ff[1][1:0], work_ff[1][31:2]};
         work_in[3] = work_ff[2];
         work_in[4] = work_ff[3];
         for (int i = 0; i < 15; i++) begin
            window_in[i] = window_ff[i + 1];
         end
         window_in[15] = sched_new;
         rnd_in = rnd_ff + 7'd1;
         if (rnd_ff == LAST_ROUND) begin
            running_in = 1'b0;
            fold_in    = 1'b1;
         end
      end
      if (fold_ff) begin
         for (int i = 0; i < 5; i++) begin
            chain_in[i] = chain_ff[i] + work_ff[i];
         end
      end
      if (ctl.reinit) begin
         chain_in = INIT_CHAIN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff   <= INIT_CHAIN;
         running_ff <= 1'b0;
         fold_ff    <= 1'b0;
      end else begin
         chain_ff   <= chain_in;
         running_ff <= running_in;
         fold_ff    <= fold_in;
      end
      work_ff   <= work_in;
      window_ff <= window_in;
      rnd_ff    <= rnd_in;
   end

   assign status.done = fold_ff;
   assign chain       = chain_ff;

endmodule

### rtl/core/sha1_message_hasher.sv
// ----------------------------------------------------------------------------
// SHA-1 message hasher
// Streaming SHA-1 over a byte stream; emits five digest words per message.
// ----------------------------------------------------------------------------
// Message bytes arrive one item at a time and are packed big-endian into a
// 16-word block buffer. A byte that does not complete a block leaves the
// hasher idle, so bytes can stream back to back. The item that carries the
// 64th byte of a block holds the input off while the round engine is
// launched, its single shared round adder runs the rounds one per cycle,
// and the result is folded into the chaining words.
// An item with end_of_message set (with or without a byte) starts padding:
// the marker byte 0x80, zeros and the 64-bit bit length fill one or, when
// fewer than nine bytes are free, two final blocks, each hashed the same
// way. The five digest words then leave on the result channel, word 0
// first, with last_word set on the fifth; the input stays stalled until
// that word is taken, after which the chaining words and the byte count
// are back at their initial values for the next message.
// An item with neither a byte nor end_of_message is taken and changes nothing.
module sha1_message_hasher (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_message_byte,
   input  logic                   req_byte_present,
   input  logic                   req_end_of_message,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output sha1mh_pkg::word_type   rsp_digest_word,
   output logic                   rsp_last_word
);
   import sha1mh_pkg::*;

   hasher_state_type  state_ff, state_in;
   block_type         block_ff, block_in;
   total_type         total_ff, total_in;
   word_idx_type      word_idx_ff, word_idx_in;
   logic              pend_eom_ff, pend_eom_in;
   logic              extra_ff, extra_in;
   logic              launched_ff, launched_in;

   engine_ctl_type    engine_ctl;
   engine_status_type engine_status;
   chain_type         chain;

   logic              req_accept;
   logic [5:0]        fill_pos;
   logic [63:0]       length_bits;

   assign req_accept  = req_valid && !req_stall;
   assign fill_pos    = total_ff[5:0];
   assign length_bits = {total_ff, 3'b000};

   sha1mh_round_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .ctl    (engine_ctl),
      .block  (block_ff),
      .status (engine_status),
      .chain  (chain)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_byte_present && fill_pos == LAST_BYTE_POS) begin
                  state_in = ST_HASH_DATA;
               end else if (req_end_of_message) begin
                  state_in = ST_PAD_FIRST;
               end
            end
         end
         ST_HASH_DATA: begin
            if (engine_status.done) begin
               state_in = pend_eom_ff ? ST_PAD_FIRST : ST_IDLE;
            end
         end
         ST_PAD_FIRST: begin
            state_in = ST_HASH_PAD;
         end
         ST_HASH_PAD: begin
            if (engine_status.done) begin
               state_in = extra_ff ? ST_PAD_LEN : ST_EMIT;
            end
         end
         ST_PAD_LEN: begin
            state_in = ST_HASH_PAD;
         end
         ST_EMIT: begin
            if (!rsp_stall && word_idx_ff == LAST_WORD_IDX) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs and engine control.
   always_comb begin
      req_stall         = (state_ff != ST_IDLE);
      rsp_valid         = (state_ff == ST_EMIT);
      rsp_last_word     = (word_idx_ff == LAST_WORD_IDX);
      engine_ctl.start  = (state_ff == ST_HASH_DATA || state_ff == ST_HASH_PAD)
                          && !launched_ff;
      engine_ctl.reinit = (state_ff == ST_EMIT) && !rsp_stall
                          && (word_idx_ff == LAST_WORD_IDX);
      case (word_idx_ff)
         3'd0:    rsp_digest_word = chain[0];
         3'd1:    rsp_digest_word = chain[1];
         3'd2:    rsp_digest_word = chain[2];
         3'd3:    rsp_digest_word = chain[3];
         default: rsp_digest_word = chain[4];
      endcase
   end

   // Block buffer, byte count and bookkeeping.
   always_comb begin
      logic [5:0] byte_pos;
      block_in    = block_ff;
      total_in    = total_ff;
      word_idx_in = word_idx_ff;
      pend_eom_in = pend_eom_ff;
      extra_in    = extra_ff;
      launched_in = launched_ff;
      byte_pos    = '0;

      // The round engine is launched once per block and rearmed when it folds.
      if (engine_ctl.start) begin
         launched_in = 1'b1;
      end else if (engine_status.done) begin
         launched_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept && req_byte_present) begin
               for (int i = 0; i < 16; i++) begin
                  for (int l = 0; l < 4; l++) begin
                     byte_pos = 6'(4 * i + l);
                     if (byte_pos == fill_pos) begin
                        block_in[i][8 * (3 - l) +: 8] = req_message_byte;
                     end
                  end
               end
               total_in    = total_ff + 61'd1;
               pend_eom_in = req_end_of_message;
            end
         end
         ST_PAD_FIRST: begin
            for (int i = 0; i < 16; i++) begin
               for (int l = 0; l < 4; l++) begin
                  byte_pos = 6'(4 * i + l);
                  if (byte_pos == fill_pos) begin
                     block_in[i][8 * (3 - l) +: 8] = PAD_MARKER;
                  end else if (byte_pos > fill_pos) begin
                     block_in[i][8 * (3 - l) +: 8] = 8'h00;
                  end
               end
            end
            // The length fits behind the marker unless it landed in the last eight bytes.
            if (fill_pos < LENGTH_OFFSET) begin
               block_in[14] = length_bits[63:32];
               block_in[15] = length_bits[31:0];
            end
            extra_in = (fill_pos >= LENGTH_OFFSET);
         end
         ST_PAD_LEN: begin
            for (int i = 0; i < 14; i++) begin
               block_in[i] = '0;
            end
            block_in[14] = length_bits[63:32];
            block_in[15] = length_bits[31:0];
            extra_in     = 1'b0;
         end
         ST_EMIT: begin
            if (!rsp_stall) begin
               if (word_idx_ff == LAST_WORD_IDX) begin
                  word_idx_in = '0;
                  total_in    = '0;
                  pend_eom_in = 1'b0;
               end else begin
                  word_idx_in = word_idx_ff + 3'd1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         total_ff    <= '0;
         word_idx_ff <= '0;
         pend_eom_ff <= 1'b0;
         extra_ff    <= 1'b0;
         launched_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         total_ff    <= total_in;
         word_idx_ff <= word_idx_in;
         pend_eom_ff <= pend_eom_in;
         extra_ff    <= extra_in;
         launched_ff <= launched_in;
      end
      block_ff <= block_in;
   end

endmodule

### rtl/core/sha1mh_checker.sv
// ----------------------------------------------------------------------------
// SHA-1 message hasher checker
// Port-level assertions on the hasher, attached by a bind statement.
// ----------------------------------------------------------------------------
`include "sha1_message_hasher_assert.svh"

module sha1mh_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic                 req_end_of_message,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input sha1mh_pkg::word_type rsp_digest_word,
   input logic                 rsp_last_word
);

   // A stalled digest word holds.
   `SHA1MH_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_digest_word) && $stable(rsp_last_word), "digest item changed while stalled")

   // Nothing is offered on the result side right after reset.
   `SHA1MH_ASSERT_ALWAYS(a_reset_quiet, reset |=> !rsp_valid, "result offered after reset")

   // Input is held off while the digest is being delivered.
   `SHA1MH_ASSERT(a_emit_stalls, rsp_valid |-> req_stall, "input taken during digest output")

   // Taking the final word ends the digest burst.
   `SHA1MH_ASSERT(a_last_ends, rsp_valid && !rsp_stall && rsp_last_word |=> !rsp_valid, "result offered after last word")

   // An end of message always starts hashing work.
   `SHA1MH_ASSERT(a_eom_busy, req_valid && !req_stall && req_end_of_message |=> req_stall, "end of message did not start padding")

endmodule

bind sha1_message_hasher sha1mh_checker u_sha1mh_checker (.*);
